@@ hdl/tlfd_pkg.sv @@
package tlfd_pkg;

	// Parser phases.
	localparam logic [1:0] PH_TYPE    = 2'd0;
	localparam logic [1:0] PH_LEN_HI  = 2'd1;
	localparam logic [1:0] PH_LEN_LO  = 2'd2;
	localparam logic [1:0] PH_PAYLOAD = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam int unsigned LIMIT_W = 17;
	localparam int unsigned LEN_W   = 16;

	localparam logic [LIMIT_W-1:0] HEADER_BYTES = LIMIT_W'(3);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(4096);

	typedef struct packed {
		logic [1:0]       phase;
		logic [7:0]       held_type;
		logic [7:0]       length_high;
		logic [LEN_W-1:0] payload_length;
		logic [LEN_W-1:0] bytes_seen;
		logic             err;
	} tlfd_state_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       frame_type;
		logic [7:0]       payload_byte;
		logic [LEN_W-1:0] byte_index;
		logic [LEN_W-1:0] frame_length;
		logic             last;
	} tlfd_result_t;

endpackage

@@ hdl/tlfd_ifs.sv @@
interface tlfd_byte_if;
	import tlfd_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface tlfd_frame_if;
	import tlfd_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [7:0]       frame_type;
	logic [7:0]       payload_byte;
	logic [LEN_W-1:0] byte_index;
	logic [LEN_W-1:0] frame_length;
	logic             last;

	modport source (
		output valid, output kind, output frame_type, output payload_byte,
		output byte_index, output frame_length, output last, input ready
	);
	modport sink (
		input valid, input kind, input frame_type, input payload_byte,
		input byte_index, input frame_length, input last, output ready
	);
endinterface

@@ hdl/type_length_frame_deframer.sv @@
// Channel   Modport   Moves                       Transfer when
// stream    sink      one raw byte (data_byte)    stream.valid && stream.ready
// frames    source    one tagged result           frames.valid && frames.ready
// cfg       write     frame_limit (17 bits)       cfg_wr_en high at clk rise
//
// The header parser updates its state and the result register in the same
// clock, so a byte is taken in every cycle while the result register is
// empty or being drained. Any byte, with or without a result, stalls while
// the result register is full and frames.ready is low.
// Reset (arst_n low) clears the parser to expect a type byte, clears the
// sticky error and sets frame_limit to 4096.
module type_length_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [tlfd_pkg::LIMIT_W-1:0]  cfg_wr_data,
	tlfd_byte_if.sink                     stream,
	tlfd_frame_if.source                  frames
);
	import tlfd_pkg::*;

	// Frame size limit, header bytes included. It is sampled only when a
	// length low byte arrives, so a write affects the next check only.
	logic [LIMIT_W-1:0] frame_limit_q;

	// Parser state: phase, header fields, payload count and sticky error.
	tlfd_state_t  state_q;
	tlfd_state_t  state_nxt;

	// Result register that parts the input side from the output side.
	tlfd_result_t result_q;
	tlfd_result_t result_nxt;
	logic         result_has;
	logic         out_valid_q;

	logic         in_fire;
	logic         out_free;

	// The result register can take a new entry when it is empty or when its
	// current entry leaves in this cycle.
	assign out_free     = !out_valid_q || frames.ready;
	assign stream.ready = out_free;
	assign in_fire      = stream.valid && out_free;

	tlfd_parser u_parser (
		.cur         (state_q),
		.data_byte   (stream.data_byte),
		.frame_limit (frame_limit_q),
		.nxt         (state_nxt),
		.res         (result_nxt),
		.res_valid   (result_has)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			frame_limit_q <= cfg_wr_data;
		end
	end

	// The all-zero state is the type byte phase with the error clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	// A byte that gives no result still empties a drained result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= in_fire && result_has;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && result_has) begin
			result_q <= result_nxt;
		end
	end

	assign frames.valid        = out_valid_q;
	assign frames.kind         = result_q.kind;
	assign frames.frame_type   = result_q.frame_type;
	assign frames.payload_byte = result_q.payload_byte;
	assign frames.byte_index   = result_q.byte_index;
	assign frames.frame_length = result_q.frame_length;
	assign frames.last         = result_q.last;

	// Once set, the error stays until reset.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.err |=> state_q.err)
		else $error("sticky error cleared without reset");

	// An error result is only ever produced with the error flag set.
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (result_q.kind == KIND_ERROR) |-> state_q.err)
		else $error("error result without sticky error");

	// Payload phase is entered only for a frame with a nonzero length.
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_PAYLOAD) |-> (state_q.payload_length != '0))
		else $error("payload phase with zero length");

	// An empty frame result always closes its frame.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (result_q.kind == KIND_EMPTY) |-> result_q.last)
		else $error("empty frame result without last");

	// The byte side never stalls while the result register is empty.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> stream.ready)
		else $error("input stalled with empty result register");

endmodule

@@ hdl/tlfd_parser.sv @@
module tlfd_parser (
	input  tlfd_pkg::tlfd_state_t            cur,
	input  logic [7:0]                       data_byte,
	input  logic [tlfd_pkg::LIMIT_W-1:0]     frame_limit,
	output tlfd_pkg::tlfd_state_t            nxt,
	output tlfd_pkg::tlfd_result_t           res,
	output logic                             res_valid
);
	import tlfd_pkg::*;

	logic [LEN_W-1:0]   len_new;
	logic [LIMIT_W-1:0] total;
	logic [LIMIT_W-1:0] seen_inc;
	logic               is_last;

	assign len_new  = {cur.length_high, data_byte};
	assign total    = HEADER_BYTES + {1'b0, len_new};
	assign seen_inc = {1'b0, cur.bytes_seen} + LIMIT_W'(1);
	assign is_last  = seen_inc >= {1'b0, cur.payload_length};

	always_comb begin
		nxt       = cur;
		res       = '0;
		res_valid = 1'b0;
		if (cur.err) begin
			// The sticky error freezes everything and reports on every byte.
			res_valid = 1'b1;
			res.kind  = KIND_ERROR;
		end else begin
			case (cur.phase)
				PH_TYPE: begin
					nxt.held_type = data_byte;
					nxt.phase     = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					nxt.length_high = data_byte;
					nxt.phase       = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					nxt.payload_length = len_new;
					nxt.bytes_seen     = '0;
					if (total > frame_limit) begin
						nxt.err   = 1'b1;
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
					end else if (len_new == '0) begin
						nxt.phase = PH_TYPE;
						res_valid = 1'b1;
						res.kind  = KIND_EMPTY;
						res.last  = 1'b1;
					end else begin
						nxt.phase = PH_PAYLOAD;
					end
				end
				default: begin
					res_valid        = 1'b1;
					res.kind         = KIND_PAYLOAD;
					res.payload_byte = data_byte;
					res.byte_index   = cur.bytes_seen;
					res.last         = is_last;
					if (is_last) begin
						nxt.phase      = PH_TYPE;
						nxt.bytes_seen = '0;
					end else begin
						nxt.bytes_seen = seen_inc[LEN_W-1:0];
					end
				end
			endcase
		end
		// Type and length in every result are those left after this byte.
		res.frame_type   = nxt.held_type;
		res.frame_length = nxt.payload_length;
	end

endmodule
